// ===== hw/rtl/plbp_pkg.sv =====
// Shared constants, codes and colour order lookup for the bit-plane packer.
`default_nettype none

package plbp_pkg;

  localparam int DEF_NUM_LEDS   = 256;
  localparam int DEF_NUM_STRIPS = 8;
  localparam int BYTES_PER_LED  = 24;
  localparam int ORDER_W        = 3;

  // x / 3 == (x * 683) >> 11 for every x below 2048
  localparam logic [10:0] RECIP3    = 11'd683;
  localparam int          RECIP3_SH = 11;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  localparam logic [ORDER_W-1:0] ORD_RGB = 3'd0;
  localparam logic [ORDER_W-1:0] ORD_GBR = 3'd1;
  localparam logic [ORDER_W-1:0] ORD_BRG = 3'd2;
  localparam logic [ORDER_W-1:0] ORD_BGR = 3'd3;
  localparam logic [ORDER_W-1:0] ORD_GRB = 3'd4;

  localparam logic [1:0] COMP_RED   = 2'd0;
  localparam logic [1:0] COMP_GREEN = 2'd1;
  localparam logic [1:0] COMP_BLUE  = 2'd2;

  function automatic logic order_valid(input logic [ORDER_W-1:0] code);
    order_valid = (code <= ORD_GRB);
  endfunction

  // Component for each 8-byte group, group g at bits 2g+1..2g.
  function automatic logic [5:0] order_map(input logic [ORDER_W-1:0] code);
    logic [5:0] m;
    m = {COMP_BLUE, COMP_GREEN, COMP_RED};
    unique case (code)
      ORD_RGB: m = {COMP_BLUE, COMP_GREEN, COMP_RED};
      ORD_GBR: m = {COMP_RED, COMP_BLUE, COMP_GREEN};
      ORD_BRG: m = {COMP_GREEN, COMP_RED, COMP_BLUE};
      ORD_BGR: m = {COMP_RED, COMP_GREEN, COMP_BLUE};
      ORD_GRB: m = {COMP_BLUE, COMP_RED, COMP_GREEN};
      default: m = {COMP_BLUE, COMP_GREEN, COMP_RED};
    endcase
    order_map = m;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/plbp_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read.
`default_nettype none

module plbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/parallel_led_bitplane_packer_core.sv =====
// Throughput: one beat per cycle, writes and reads mixed, except while clearing or while
//   a stage-1 read waits on out_ready; the LED-wide read-modify-write loop through the
//   single buffer RAM sets it, with a bypass of the last written row.
// Reset: synchronous; then a clearing pass zeroes the buffer one LED row per cycle, with
//   in_ready low. Colour orders reset to zero. Read beats pass stage 1, then read_byte.
`default_nettype none

module parallel_led_bitplane_packer_core import plbp_pkg::*; #(
  parameter int NUM_LEDS   = DEF_NUM_LEDS,
  parameter int NUM_STRIPS = DEF_NUM_STRIPS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [23:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        cmd,
  input  logic [2:0]  strip,
  input  logic [7:0]  led_index,
  input  logic [7:0]  red,
  input  logic [7:0]  green,
  input  logic [7:0]  blue,
  input  logic [12:0] byte_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  read_byte
);

  localparam int LED_AW = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
  localparam int WORD_W = BYTES_PER_LED * NUM_STRIPS;
  localparam logic [31:0] BUF_BYTES_W  = 32'(NUM_LEDS * BYTES_PER_LED);
  localparam logic [31:0] NUM_LEDS_W   = 32'(NUM_LEDS);
  localparam logic [31:0] NUM_STRIPS_W = 32'(NUM_STRIPS);
  localparam logic [LED_AW-1:0] LAST_ROW = LED_AW'(NUM_LEDS - 1);

  logic [23:0] strip_color_orders;

  // clearing pass
  logic              clearing;
  logic [LED_AW-1:0] clr_addr;

  // accept-side decode
  logic        accept;
  logic [9:0]  grp8;
  logic [20:0] recip_prod;
  logic [9:0]  led_q;
  logic [13:0] k_full;
  logic        rd_ok;
  logic        wr_ok;
  logic [31:0] led_ext;

  // stage 1
  logic              s1_valid;
  logic              s1_cmd;
  logic              s1_ok;
  logic [LED_AW-1:0] s1_addr;
  logic [4:0]        s1_k;
  logic [2:0]        s1_strip;
  logic [7:0]        s1_red;
  logic [7:0]        s1_green;
  logic [7:0]        s1_blue;
  logic              s1_adv;
  logic              s1_wr_fire;
  logic              s1_is_read;
  logic [ORDER_W-1:0] s1_code;
  logic [5:0]        s1_map;
  logic [7:0]        comp [3];
  logic [WORD_W-1:0] cur_word;
  logic [WORD_W-1:0] word_new;
  logic [NUM_STRIPS-1:0] rd_slice;
  logic [7:0]        rd_byte;
  logic              out_load;

  // bypass of the most recent RAM write
  logic [LED_AW-1:0] fwd_addr;
  logic [WORD_W-1:0] fwd_data;

  // RAM ports
  logic              ram_we;
  logic [LED_AW-1:0] ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [WORD_W-1:0] ram_rdata;

  plbp_ram #(
    .WIDTH (WORD_W),
    .DEPTH (NUM_LEDS)
  ) u_buf (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (led_ext[LED_AW-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      strip_color_orders <= '0;
    end else if (cfg_we) begin
      strip_color_orders <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == LAST_ROW) begin
        clearing <= 1'b0;
      end
    end
  end

  // byte_index / 24 as ((byte_index >> 3) * 683) >> 11
  always_comb begin
    grp8       = byte_index[12:3];
    recip_prod = {11'd0, grp8} * {10'd0, RECIP3};
    led_q      = recip_prod[20:RECIP3_SH];
    k_full     = {1'b0, byte_index} - ({led_q, 4'd0} + {1'b0, led_q, 3'd0});
    rd_ok      = {19'd0, byte_index} < BUF_BYTES_W;
    wr_ok      = ({24'd0, led_index} < NUM_LEDS_W) && ({29'd0, strip} < NUM_STRIPS_W);
    led_ext    = (cmd == CMD_READ) ? {22'd0, led_q} : {24'd0, led_index};
  end

  assign s1_is_read = s1_valid && (s1_cmd == CMD_READ);
  assign s1_adv     = !s1_is_read || !out_valid || out_ready;
  assign in_ready   = !clearing && (!s1_valid || s1_adv);
  assign accept     = in_valid && in_ready;
  assign out_load   = s1_is_read && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cmd   <= cmd;
      s1_ok    <= (cmd == CMD_READ) ? rd_ok : wr_ok;
      s1_addr  <= led_ext[LED_AW-1:0];
      s1_k     <= k_full[4:0];
      s1_strip <= strip;
      s1_red   <= red;
      s1_green <= green;
      s1_blue  <= blue;
    end
  end

  // RAM read is read-first; take the row just written when the addresses meet
  assign cur_word = (s1_addr == fwd_addr) ? fwd_data : ram_rdata;

  always_comb begin
    s1_code    = strip_color_orders[ORDER_W*s1_strip +: ORDER_W];
    s1_map     = order_map(s1_code);
    s1_wr_fire = s1_valid && (s1_cmd == CMD_WRITE) && s1_ok && order_valid(s1_code);
    for (int g = 0; g < 3; g++) begin
      case (s1_map[2*g +: 2])
        COMP_RED:   comp[g] = s1_red;
        COMP_GREEN: comp[g] = s1_green;
        default:    comp[g] = s1_blue;
      endcase
    end
  end

  always_comb begin
    word_new = cur_word;
    for (int k = 0; k < BYTES_PER_LED; k++) begin
      for (int s = 0; s < NUM_STRIPS; s++) begin
        if (s1_strip == 3'(s)) begin
          word_new[k*NUM_STRIPS + s] = comp[k/8][7 - (k%8)];
        end
      end
    end
  end

  always_comb begin
    rd_slice = cur_word[s1_k*NUM_STRIPS +: NUM_STRIPS];
    rd_byte  = '0;
    if (s1_ok) begin
      rd_byte[NUM_STRIPS-1:0] = rd_slice;
    end
  end

  always_comb begin
    if (clearing) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else begin
      ram_we    = s1_wr_fire;
      ram_waddr = s1_addr;
      ram_wdata = word_new;
    end
  end

  always_ff @(posedge clk) begin
    if (ram_we) begin
      fwd_addr <= ram_waddr;
      fwd_data <= ram_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      read_byte <= rd_byte;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/plbp_checker.sv =====
// Port-level checks for the bit-plane packer, bound to the top level.
`default_nettype none

module plbp_checker import plbp_pkg::*; (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       cmd,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] read_byte
);

  logic [2:0] pend;
  logic [2:0] pend_next;
  logic       rd_beat;
  logic       out_beat;

  assign rd_beat  = in_valid && in_ready && (cmd == CMD_READ);
  assign out_beat = out_valid && out_ready;

  always_comb begin
    pend_next = pend + {2'd0, rd_beat} - {2'd0, out_beat};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
    end else begin
      pend <= pend_next;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(read_byte))
    else $error("output beat changed while stalled");

  a_clear_after_reset: assert property (@(posedge clk)
    rst |=> !in_ready)
    else $error("input ready during buffer clear");

  a_no_spurious_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pend != 3'd0)
    else $error("output beat without an outstanding read");

  a_pend_bound: assert property (@(posedge clk) disable iff (rst)
    pend <= 3'd2)
    else $error("more reads in flight than pipeline holds");

endmodule

bind parallel_led_bitplane_packer_core plbp_checker u_plbp_checker (.*);

`default_nettype wire
